[rtl/core/spq_pkg.sv]
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  // entry_count and position are 5-bit fields
  localparam int unsigned CNT_W       = 5;

  typedef enum logic [2:0] {
    MODE_INSERT    = 3'd0,
    MODE_REM_LAST  = 3'd1,
    MODE_REM_FIRST = 3'd2,
    MODE_REM_POS   = 3'd3,
    MODE_COUNT     = 3'd4,
    MODE_CLEAR     = 3'd5
  } spq_mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] item_value;
    logic [31:0]       item_priority;
    logic [CNT_W-1:0]  position;
  } spq_in_t;

  typedef struct packed {
    spq_status_e       status;
    logic [CNT_W-1:0]  entry_count;
    logic signed [31:0] removed_value;
    logic [31:0]       removed_priority;
  } spq_out_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [31:0]        prio;
  } spq_entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    spq_entry_t       ins_entry;
    logic [IDX_W-1:0] rem_idx;
  } spq_cmd_t;

endpackage

[rtl/core/spq_cell.sv]
module spq_cell
  import spq_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [CNT_W-1:0] count_i,
  input  spq_cmd_t         cmd_i,
  input  logic             prev_ge_i,
  input  spq_entry_t       left_i,
  input  spq_entry_t       right_i,
  output logic             ge_o,
  output spq_entry_t       entry_o,
  output spq_entry_t       rem_o
);

  spq_entry_t entry_q, entry_d;
  logic       occ;

  assign occ  = CNT_W'(cell_idx_i) < count_i;
  // occupied and not outranked by the new entry: stays put on insert
  assign ge_o = occ && (entry_q.prio >= cmd_i.ins_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins && !ge_o) begin
      entry_d = prev_ge_i ? cmd_i.ins_entry : left_i;
    end else if (cmd_i.rem && (cell_idx_i >= cmd_i.rem_idx)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rem_o   = (cmd_i.rem && (cell_idx_i == cmd_i.rem_idx)) ? entry_q : '0;

endmodule

[rtl/core/sorted_priority_queue_core.sv]
// Channel  Direction  Handshake                Beat
// in       input      in_valid_i / in_stall_o  spq_in_t   (mode, item, position)
// out      output     out_valid_o / out_stall_i spq_out_t (status, count, removed entry)
//
// One operation per cycle while in_stall_o is low: every cell compares and shifts in
// parallel, so a beat taken at one edge is loaded into the output register at that
// same edge and can be taken from the next edge on.
// Reset clears the entry count and the output valid; cell contents are not reset.
// in_stall_o is raised only while a result sits in the output register and the
// sink stalls it.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spq_out_t out_data_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  spq_out_t         out_data_q, out_data_d;
  logic             in_fire;

  spq_cmd_t         cmd;
  spq_status_e      status;
  logic             empty, full;
  logic [CNT_W-1:0] pos_m1, cnt_m1;

  logic       ge_chain [QUEUE_DEPTH:0];
  spq_entry_t ent_ext  [QUEUE_DEPTH+1:0];
  spq_entry_t rem_ent  [QUEUE_DEPTH-1:0];
  spq_entry_t rem_sum;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign empty  = (count_q == '0);
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign pos_m1 = in_data_i.position - CNT_W'(1);
  assign cnt_m1 = count_q - CNT_W'(1);

  always_comb begin
    cmd.ins       = 1'b0;
    cmd.rem       = 1'b0;
    cmd.ins_entry = '{value: in_data_i.item_value, prio: in_data_i.item_priority};
    cmd.rem_idx   = '0;
    status        = ST_OK;
    count_d       = count_q;
    unique case (spq_mode_e'(in_data_i.mode))
      MODE_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins = in_fire;
          count_d = count_q + CNT_W'(1);
        end
      end
      MODE_REM_LAST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.rem     = in_fire;
          cmd.rem_idx = cnt_m1[IDX_W-1:0];
          count_d     = cnt_m1;
        end
      end
      MODE_REM_FIRST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.rem = in_fire;
          count_d = cnt_m1;
        end
      end
      MODE_REM_POS: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if ((in_data_i.position == '0) || (in_data_i.position > count_q)) begin
          status = ST_BADPOS;
        end else begin
          cmd.rem     = in_fire;
          cmd.rem_idx = pos_m1[IDX_W-1:0];
          count_d     = cnt_m1;
        end
      end
      MODE_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign ge_chain[0]             = 1'b1;
  assign ent_ext[0]              = '0;
  assign ent_ext[QUEUE_DEPTH+1]  = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .count_i    (count_q),
      .cmd_i      (cmd),
      .prev_ge_i  (ge_chain[g]),
      .left_i     (ent_ext[g]),
      .right_i    (ent_ext[g+2]),
      .ge_o       (ge_chain[g+1]),
      .entry_o    (ent_ext[g+1]),
      .rem_o      (rem_ent[g])
    );
  end

  // at most one cell reports a hit, the rest give zero
  always_comb begin
    rem_sum = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      rem_sum = rem_sum | rem_ent[k];
    end
  end

  always_comb begin
    out_data_d.status           = status;
    out_data_d.entry_count      = count_d;
    out_data_d.removed_value    = rem_sum.value;
    out_data_d.removed_priority = rem_sum.prio;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.status != ST_OK) |->
      (out_data_q.removed_value == '0) && (out_data_q.removed_priority == '0))
    else $error("removed entry reported on an error");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_data_i.mode == MODE_INSERT) && !full |=>
      count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_count_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q && (out_data_q.entry_count == count_q))
    else $error("reported count differs from held count");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam logic [2:0] MODE_UNUSED_A = 3'd6;
  localparam logic [2:0] MODE_UNUSED_B = 3'd7;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned RANDOM_BEATS = 800;

  typedef enum {FILL, DRAIN, MIXED} load_phase_e;

  typedef struct {
    spq_in_t  beat;
    bit       typed;
    spq_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  spq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_data;

  // shadow of the queue contents, updated on every accepted beat
  logic signed [31:0] held_val [QUEUE_DEPTH];
  logic [31:0]        held_pri [QUEUE_DEPTH];
  int unsigned        held_cnt = 0;

  spq_out_t    outcomes_due[$];
  bit          want_typed = 1'b0;
  spq_out_t    typed_want = '0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          in_calm = 1'b0;
  int unsigned stall_left = 0;
  stim_row_t   dir_rows[$];

  sorted_priority_queue_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void take_entry(input int unsigned idx, inout spq_out_t r);
    int unsigned k;
    r.removed_value    = held_val[idx];
    r.removed_priority = held_pri[idx];
    for (k = idx; k + 1 < held_cnt; k++) begin
      held_val[k] = held_val[k + 1];
      held_pri[k] = held_pri[k + 1];
    end
    held_cnt--;
  endfunction

  function automatic spq_out_t apply_op(input spq_in_t b);
    spq_out_t    r;
    int unsigned at;
    int unsigned k;
    r = '0;
    r.status = ST_OK;
    case (b.mode)
      MODE_INSERT: begin
        if (held_cnt == QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // goes behind every entry of equal or higher priority
          at = 0;
          while (at < held_cnt && held_pri[at] >= b.item_priority) at++;
          for (k = held_cnt; k > at; k--) begin
            held_val[k] = held_val[k - 1];
            held_pri[k] = held_pri[k - 1];
          end
          held_val[at] = b.item_value;
          held_pri[at] = b.item_priority;
          held_cnt++;
        end
      end
      MODE_REM_LAST: begin
        if (held_cnt == 0) r.status = ST_EMPTY;
        else take_entry(held_cnt - 1, r);
      end
      MODE_REM_FIRST: begin
        if (held_cnt == 0) r.status = ST_EMPTY;
        else take_entry(0, r);
      end
      MODE_REM_POS: begin
        // empty check wins over the position check
        if (held_cnt == 0) r.status = ST_EMPTY;
        else if (b.position == 0 || b.position > held_cnt) r.status = ST_BADPOS;
        else take_entry(b.position - 1, r);
      end
      MODE_CLEAR: held_cnt = 0;
      default: ;
    endcase
    r.entry_count = CNT_W'(held_cnt);
    return r;
  endfunction

  function automatic stim_row_t dir_row(input logic [2:0] mode, input logic [31:0] val,
                                        input logic [31:0] pri, input logic [4:0] pos,
                                        input bit typed, input spq_status_e st,
                                        input logic [4:0] cnt, input logic [31:0] rv,
                                        input logic [31:0] rp);
    stim_row_t row;
    row.beat.mode          = mode;
    row.beat.item_value    = val;
    row.beat.item_priority = pri;
    row.beat.position      = pos;
    row.typed              = typed;
    row.want.status        = st;
    row.want.entry_count   = cnt;
    row.want.removed_value = rv;
    row.want.removed_priority = rp;
    return row;
  endfunction

  function automatic logic [2:0] pick_mode(input int unsigned r, input int unsigned t_ins,
                                           input int unsigned t_pos, input int unsigned t_first,
                                           input int unsigned t_last, input int unsigned t_cnt,
                                           input int unsigned t_clr);
    if (r < t_ins) return MODE_INSERT;
    if (r < t_pos) return MODE_REM_POS;
    if (r < t_first) return MODE_REM_FIRST;
    if (r < t_last) return MODE_REM_LAST;
    if (r < t_cnt) return MODE_COUNT;
    if (r < t_clr) return MODE_CLEAR;
    return ($urandom_range(0, 1) != 0) ? MODE_UNUSED_A : MODE_UNUSED_B;
  endfunction

  function automatic spq_in_t random_beat(input load_phase_e ph);
    spq_in_t     b;
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    case (ph)
      FILL:    b.mode = pick_mode(r, 70, 78, 84, 89, 95, 97);
      DRAIN:   b.mode = pick_mode(r, 15, 40, 58, 76, 88, 92);
      default: b.mode = pick_mode(r, 40, 60, 72, 84, 91, 95);
    endcase
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: b.item_value = 32'h8000_0000;
        1: b.item_value = 32'h7fff_ffff;
        2: b.item_value = 32'h0;
        default: b.item_value = 32'hffff_ffff;
      endcase
    end else begin
      b.item_value = $urandom;
    end
    // narrow priorities often, so equal priorities keep turning up
    r = $urandom_range(0, 99);
    if (r < 40) begin
      b.item_priority = $urandom_range(0, 7);
    end else if (r < 50) begin
      case ($urandom_range(0, 3))
        0: b.item_priority = 32'h0;
        1: b.item_priority = 32'hffff_ffff;
        2: b.item_priority = 32'h7fff_ffff;
        default: b.item_priority = 32'h8000_0000;
      endcase
    end else begin
      b.item_priority = $urandom;
    end
    top = (held_cnt == 0) ? 1 : held_cnt;
    r = $urandom_range(0, 99);
    if (r < 80) b.position = CNT_W'($urandom_range(1, top));
    else if (r < 90) b.position = '0;
    else b.position = CNT_W'($urandom_range(0, 31));
    return b;
  endfunction

  function automatic int unsigned beat_gap();
    int unsigned r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input spq_in_t b, input bit typed, input spq_out_t want);
    int unsigned idle;
    idle = beat_gap();
    if (idle != 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_data    = b;
    want_typed = typed;
    typed_want = want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sink stall: short bursts, occasional long holds, and calm stretches
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  = 1'b0;
      stall_left = $urandom_range(20, 80);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_stall  = 1'b0;
          stall_left = $urandom_range(0, 3);
        end
        6, 7, 8: begin
          out_stall  = 1'b1;
          stall_left = $urandom_range(0, 2);
        end
        default: begin
          out_stall  = 1'b1;
          stall_left = $urandom_range(10, 40);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    spq_out_t calc;
    spq_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        calc = apply_op(in_data);
        outcomes_due.push_back(want_typed ? typed_want : calc);
      end
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing pending: st=%0d cnt=%0d val=%0d pri=%0h",
                     $realtime, out_data.status, out_data.entry_count,
                     out_data.removed_value, out_data.removed_priority);
        end else begin
          want = outcomes_due.pop_front();
          if (out_data.status !== want.status ||
              out_data.entry_count !== want.entry_count ||
              out_data.removed_value !== want.removed_value ||
              out_data.removed_priority !== want.removed_priority) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: want st=%0d cnt=%0d val=%0d pri=%0h, got st=%0d cnt=%0d val=%0d pri=%0h",
                       $realtime, want.status, want.entry_count, want.removed_value,
                       want.removed_priority, out_data.status, out_data.entry_count,
                       out_data.removed_value, out_data.removed_priority);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAIL sorted_priority_queue_core");
          $finish;
        end
      end
    end
  end

  initial begin
    spq_in_t     b;
    load_phase_e ph;
    int unsigned n;

    dir_rows.push_back(dir_row(MODE_COUNT, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_LAST, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_FIRST, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 1, 1, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 0,
                               1, ST_OK, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 0, 1, ST_BADPOS, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 2, 1, ST_BADPOS, 1, 0, 0));
    // single entry: remove last must leave the queue empty
    dir_rows.push_back(dir_row(MODE_REM_LAST, 0, 0, 0, 1, ST_OK, 0,
                               32'h7fff_ffff, 32'hffff_ffff));
    dir_rows.push_back(dir_row(MODE_INSERT, 32'h8000_0000, 0, 0, 1, ST_OK, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_INSERT, 5, 0, 0, 1, ST_OK, 2, 0, 0));
    dir_rows.push_back(dir_row(MODE_INSERT, 32'hffff_ffff, 7, 0, 1, ST_OK, 3, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_FIRST, 0, 0, 0, 1, ST_OK, 2, 32'hffff_ffff, 7));
    // equal priorities leave in arrival order
    dir_rows.push_back(dir_row(MODE_REM_FIRST, 0, 0, 0, 1, ST_OK, 1, 32'h8000_0000, 0));
    dir_rows.push_back(dir_row(MODE_UNUSED_A, 32'hffff_ffff, 32'hffff_ffff, 31,
                               1, ST_OK, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_UNUSED_B, 0, 0, 0, 1, ST_OK, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_INSERT, 3, 0, 0, 1, ST_OK, 2, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 2, 1, ST_OK, 1, 3, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 31, 1, ST_BADPOS, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_COUNT, 0, 0, 0, 1, ST_OK, 1, 0, 0));
    dir_rows.push_back(dir_row(MODE_INSERT, 32'h1234_5678, 32'h8000_0000, 0,
                               0, ST_OK, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_REM_POS, 0, 0, 1, 0, ST_OK, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    dir_rows.push_back(dir_row(MODE_INSERT, 1, 32'h7fff_ffff, 0, 0, ST_OK, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    // run the store up to full and beyond so the drop path is hit
    for (n = 0; n < QUEUE_DEPTH + 2; n++) begin
      b = random_beat(FILL);
      b.mode = MODE_INSERT;
      send_beat(b, 1'b0, '0);
    end

    ph = MIXED;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: ph = FILL;
          1: ph = DRAIN;
          default: ph = MIXED;
        endcase
        in_calm = ($urandom_range(0, 3) == 0);
      end
      send_beat(random_beat(ph), 1'b0, '0);
    end
    in_valid = 1'b0;

    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS sorted_priority_queue_core");
    end else begin
      $display("FAIL sorted_priority_queue_core");
    end
    $finish;
  end

endmodule

[sorted_priority_queue_core.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
sim/tb_top.sv
